// ===== rtl/trhfe_pkg.sv =====
package trhfe_pkg;

    // Fixed-point formats
    localparam int Q_W    = 48;               // Q16.32 signed
    localparam int SUM_W  = 63;               // Q31.32 unsigned
    localparam int CNT_W  = 17;               // scored step counter
    localparam int CNT_MAX = 2 ** CNT_W - 1;
    localparam int HALF_W = Q_W / 2;          // multiplier operand slice
    localparam int ACC_W  = 2 * Q_W;          // full product width
    localparam int FRAC_W = 32;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Configuration port
    localparam int APB_DW = 64;
    localparam int APB_AW = 6;
    localparam int REG_LSB = 3;               // 8-byte register stride

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]      SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        REG_RATE_ONE,
        REG_RATE_TWO,
        REG_RESERVE_ONE,
        REG_RESERVE_TWO,
        REG_START_ONE,
        REG_START_TWO,
        REG_GAIN_ONE,
        REG_GAIN_TWO
    } t_reg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0] rate_one;
        logic signed [Q_W-1:0] rate_two;
        logic signed [Q_W-1:0] reserve_one;
        logic signed [Q_W-1:0] reserve_two;
        logic signed [Q_W-1:0] start_one;
        logic signed [Q_W-1:0] start_two;
        logic signed [Q_W-1:0] gain_one;
        logic signed [Q_W-1:0] gain_two;
    } t_cfg;

    // Shared multiplier request / response
    typedef struct packed {
        logic                  start;
        logic signed [Q_W-1:0] a;
        logic signed [Q_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] q;   // rounded, saturated signed product
        logic [SUM_W-1:0]      m;   // rounded magnitude product
    } t_mul_rsp;

    // Divider request / response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVAIL1,
        ST_M1A,
        ST_M1B,
        ST_M2A,
        ST_M2B,
        ST_G1,
        ST_G2,
        ST_RES,
        ST_SQ,
        ST_FIN,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/trhfe_if.sv =====
// Input step channel
interface trhfe_in_if;
    import trhfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  first_step;
    logic                  score_step;
    logic signed [Q_W-1:0] measured_flow;
    logic                  last_step;

    modport source (output valid, first_step, score_step, measured_flow, last_step,
                    input ready);
    modport sink   (input valid, first_step, score_step, measured_flow, last_step,
                    output ready);
    modport mon    (input valid, ready, first_step, score_step, measured_flow,
                    last_step);
endinterface

// Result channel
interface trhfe_out_if;
    import trhfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] model_power;
    logic signed [Q_W-1:0] residual;
    logic [SUM_W-1:0]      mean_error;
    logic                  done_res;

    modport source (output valid, model_power, residual, mean_error, done_res,
                    input ready);
    modport sink   (input valid, model_power, residual, mean_error, done_res,
                    output ready);
    modport mon    (input valid, ready, model_power, residual, mean_error, done_res);
endinterface

// ===== rtl/two_reaction_heat_flow_error_top.sv =====
// Throughput: one step at a time; up to seven products (the seventh is the residual
//   square, on scored steps only) share one 24x24 multiplier, and the mean uses a
//   one-bit-per-cycle divider.
// Reset: synchronous active-low; clears the state register, concentrations, error
//   sum, count and both handshakes. No clearing pass.
module two_reaction_heat_flow_error_top #(
    parameter int MAX_STEPS = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    trhfe_in_if.sink                      i_in,
    trhfe_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trhfe_pkg::APB_AW-1:0]  paddr,
    input  logic [trhfe_pkg::APB_DW-1:0]  pwdata,
    output logic [trhfe_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import trhfe_pkg::*;

    localparam int CAP_I = (MAX_STEPS < CNT_MAX) ? MAX_STEPS : CNT_MAX;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_I);

    t_cfg      cfg;
    t_mul_req  mul_req;
    t_mul_rsp  mul_rsp;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    t_state                r_state, n_state;
    logic                  r_score, n_score;
    logic                  r_last, n_last;
    logic signed [Q_W-1:0] r_meas, n_meas;
    logic signed [Q_W-1:0] r_conc1, n_conc1;
    logic signed [Q_W-1:0] r_conc2, n_conc2;
    logic signed [Q_W-1:0] r_d1, n_d1;
    logic signed [Q_W-1:0] r_d2, n_d2;
    logic signed [Q_W-1:0] r_g1, n_g1;
    logic signed [Q_W-1:0] r_power, n_power;
    logic signed [Q_W-1:0] r_resid, n_resid;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [SUM_W-1:0]      r_mean, n_mean;
    logic                  r_out_valid, n_out_valid;
    logic signed [Q_W-1:0] r_out_power, n_out_power;
    logic signed [Q_W-1:0] r_out_resid, n_out_resid;
    logic [SUM_W-1:0]      r_out_mean, n_out_mean;
    logic                  r_out_done, n_out_done;

    logic signed [Q_W-1:0] avail1;
    logic signed [Q_W-1:0] avail2;
    logic signed [Q_W-1:0] resid_c;
    logic [SUM_W:0]        sum_ext;

    function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} + {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
        return s[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        s = {a[Q_W-1], a} - {b[Q_W-1], b};
        if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
        return s[Q_W-1:0];
    endfunction

    trhfe_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trhfe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    trhfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // remaining reactant of each reaction, from the old concentration
    assign avail1  = sat_sub(cfg.reserve_one, sat_sub(r_conc1, cfg.start_one));
    assign avail2  = sat_sub(cfg.reserve_two, sat_sub(r_conc2, cfg.start_two));
    assign resid_c = sat_sub(r_meas, r_power);
    assign sum_ext = {1'b0, r_sum} + {1'b0, mul_rsp.m};

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.model_power = r_out_power;
    assign o_out.residual    = r_out_resid;
    assign o_out.mean_error  = r_out_mean;
    assign o_out.done_res    = r_out_done;

    // sequencer: next state and datapath selects
    always_comb begin
        n_state     = r_state;
        n_score     = r_score;
        n_last      = r_last;
        n_meas      = r_meas;
        n_conc1     = r_conc1;
        n_conc2     = r_conc2;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_g1        = r_g1;
        n_power     = r_power;
        n_resid     = r_resid;
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_mean      = r_mean;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_power = r_out_power;
        n_out_resid = r_out_resid;
        n_out_mean  = r_out_mean;
        n_out_done  = r_out_done;

        mul_req.start    = 1'b0;
        mul_req.a        = cfg.rate_one;
        mul_req.b        = avail1;
        div_req.start    = 1'b0;
        div_req.dividend = r_sum;
        div_req.divisor  = r_cnt;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_score = i_in.score_step;
                    n_last  = i_in.last_step;
                    n_meas  = i_in.measured_flow;
                    if (i_in.first_step) begin
                        n_conc1 = cfg.start_one;
                        n_conc2 = cfg.start_two;
                        n_sum   = '0;
                        n_cnt   = '0;
                    end
                    n_state = ST_AVAIL1;
                end
            end
            ST_AVAIL1: begin
                // rate_one * avail1
                mul_req.start = 1'b1;
                n_state       = ST_M1A;
            end
            ST_M1A: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.q;
                    mul_req.b     = r_conc1;
                    n_state       = ST_M1B;
                end
            end
            ST_M1B: begin
                if (mul_rsp.done) begin
                    n_d1          = mul_rsp.q;
                    n_conc1       = sat_add(r_conc1, mul_rsp.q);
                    mul_req.start = 1'b1;
                    mul_req.a     = cfg.rate_two;
                    mul_req.b     = avail2;
                    n_state       = ST_M2A;
                end
            end
            ST_M2A: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mul_rsp.q;
                    mul_req.b     = r_conc2;
                    n_state       = ST_M2B;
                end
            end
            ST_M2B: begin
                if (mul_rsp.done) begin
                    n_d2          = mul_rsp.q;
                    n_conc2       = sat_add(r_conc2, mul_rsp.q);
                    mul_req.start = 1'b1;
                    mul_req.a     = cfg.gain_one;
                    mul_req.b     = r_d1;
                    n_state       = ST_G1;
                end
            end
            ST_G1: begin
                if (mul_rsp.done) begin
                    n_g1          = mul_rsp.q;
                    mul_req.start = 1'b1;
                    mul_req.a     = cfg.gain_two;
                    mul_req.b     = r_d2;
                    n_state       = ST_G2;
                end
            end
            ST_G2: begin
                if (mul_rsp.done) begin
                    n_power = sat_add(r_g1, mul_rsp.q);
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                // residual and its square on scored steps
                if (r_score) begin
                    n_resid       = resid_c;
                    mul_req.start = 1'b1;
                    mul_req.a     = resid_c;
                    mul_req.b     = resid_c;
                    n_state       = ST_SQ;
                end else begin
                    n_resid = '0;
                    n_state = ST_FIN;
                end
            end
            ST_SQ: begin
                if (mul_rsp.done) begin
                    n_sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                    if (r_cnt < COUNT_CAP) n_cnt = r_cnt + 1'b1;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_mean = '0;
                if (r_last && (r_cnt != '0)) begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_mean  = div_rsp.quot;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // load the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_power = r_power;
                    n_out_resid = r_resid;
                    n_out_mean  = r_mean;
                    n_out_done  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_conc1     <= '0;
            r_conc2     <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_conc1     <= n_conc1;
            r_conc2     <= n_conc2;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_score     <= n_score;
        r_last      <= n_last;
        r_meas      <= n_meas;
        r_d1        <= n_d1;
        r_d2        <= n_d2;
        r_g1        <= n_g1;
        r_power     <= n_power;
        r_resid     <= n_resid;
        r_mean      <= n_mean;
        r_out_power <= n_out_power;
        r_out_resid <= n_out_resid;
        r_out_mean  <= n_out_mean;
        r_out_done  <= n_out_done;
    end

endmodule

// ===== rtl/trhfe_apb.sv =====
module trhfe_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [trhfe_pkg::APB_AW-1:0]   paddr,
    input  logic [trhfe_pkg::APB_DW-1:0]   pwdata,
    output logic [trhfe_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    output trhfe_pkg::t_cfg                o_cfg
);
    import trhfe_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    function automatic logic [APB_DW-1:0] sext(input logic signed [Q_W-1:0] v);
        return {{(APB_DW-Q_W){v[Q_W-1]}}, v};
    endfunction

    assign idx    = t_reg_idx'(paddr[APB_AW-1:REG_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_RATE_ONE:    r_cfg.rate_one    <= pwdata[Q_W-1:0];
                REG_RATE_TWO:    r_cfg.rate_two    <= pwdata[Q_W-1:0];
                REG_RESERVE_ONE: r_cfg.reserve_one <= pwdata[Q_W-1:0];
                REG_RESERVE_TWO: r_cfg.reserve_two <= pwdata[Q_W-1:0];
                REG_START_ONE:   r_cfg.start_one   <= pwdata[Q_W-1:0];
                REG_START_TWO:   r_cfg.start_two   <= pwdata[Q_W-1:0];
                REG_GAIN_ONE:    r_cfg.gain_one    <= pwdata[Q_W-1:0];
                REG_GAIN_TWO:    r_cfg.gain_two    <= pwdata[Q_W-1:0];
            endcase
        end
    end

    // read mux, sign extended
    always_comb begin
        unique case (idx)
            REG_RATE_ONE:    prdata = sext(r_cfg.rate_one);
            REG_RATE_TWO:    prdata = sext(r_cfg.rate_two);
            REG_RESERVE_ONE: prdata = sext(r_cfg.reserve_one);
            REG_RESERVE_TWO: prdata = sext(r_cfg.reserve_two);
            REG_START_ONE:   prdata = sext(r_cfg.start_one);
            REG_START_TWO:   prdata = sext(r_cfg.start_two);
            REG_GAIN_ONE:    prdata = sext(r_cfg.gain_one);
            REG_GAIN_TWO:    prdata = sext(r_cfg.gain_two);
        endcase
    end

endmodule

// ===== rtl/trhfe_mul.sv =====
// Sign-magnitude Q16.32 multiplier built on one 24x24 multiplier.
// Four partial products are accumulated in turn, then the sum is rounded.
module trhfe_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  trhfe_pkg::t_mul_req   i_req,
    output trhfe_pkg::t_mul_rsp   o_rsp
);
    import trhfe_pkg::*;

    logic                     r_busy;
    logic                     r_round;
    logic [1:0]               r_step;
    logic [Q_W-1:0]           r_ma;
    logic [Q_W-1:0]           r_mb;
    logic                     r_neg;
    logic [ACC_W-1:0]         r_acc;
    logic                     r_done;
    logic signed [Q_W-1:0]    r_q;
    logic [SUM_W-1:0]         r_m;

    logic [HALF_W-1:0]        a_half;
    logic [HALF_W-1:0]        b_half;
    logic [2*HALF_W-1:0]      pp;
    logic [ACC_W-1:0]         pp_sh;
    logic [ACC_W-FRAC_W-1:0]  rnd;
    logic signed [Q_W-1:0]    q_sat;

    function automatic logic [Q_W-1:0] mag(input logic signed [Q_W-1:0] v);
        return v[Q_W-1] ? (~v + 1'b1) : v;
    endfunction

    // partial product: low/low, high/low, low/high, high/high
    assign a_half = r_step[0] ? r_ma[Q_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign b_half = r_step[1] ? r_mb[Q_W-1:HALF_W] : r_mb[HALF_W-1:0];
    assign pp     = a_half * b_half;

    always_comb begin
        unique case (r_step)
            2'd0:    pp_sh = ACC_W'(pp);
            2'd1,
            2'd2:    pp_sh = ACC_W'(pp) << HALF_W;
            default: pp_sh = ACC_W'(pp) << (2 * HALF_W);
        endcase
    end

    // round to nearest, ties away from zero, then saturate to Q16.32
    assign rnd = r_acc[ACC_W-1:FRAC_W] + (ACC_W-FRAC_W)'(r_acc[FRAC_W-1]);

    always_comb begin
        if (r_neg) begin
            if (rnd > ((ACC_W-FRAC_W)'(1) << (Q_W-1))) q_sat = Q_MIN;
            else                                       q_sat = -$signed(rnd[Q_W-1:0]);
        end else begin
            if (rnd > (ACC_W-FRAC_W)'(Q_MAX)) q_sat = Q_MAX;
            else                              q_sat = $signed(rnd[Q_W-1:0]);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_round <= 1'b0;
                r_step  <= '0;
            end else if (r_busy && !r_round) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) r_round <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_round <= 1'b0;
                r_done  <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= mag(i_req.a);
            r_mb  <= mag(i_req.b);
            r_neg <= i_req.a[Q_W-1] ^ i_req.b[Q_W-1];
            r_acc <= '0;
        end else if (r_busy && !r_round) begin
            r_acc <= r_acc + pp_sh;
        end else if (r_busy) begin
            r_q <= q_sat;
            r_m <= rnd[SUM_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.m    = r_m;

endmodule

// ===== rtl/trhfe_div.sv =====
// Restoring divider, one quotient bit per cycle.
module trhfe_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  trhfe_pkg::t_div_req   i_req,
    output trhfe_pkg::t_div_rsp   o_rsp
);
    import trhfe_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_div;
    logic [SUM_W-1:0]      r_quo;

    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        diff;
    logic                  ge;

    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ===== rtl/trhfe_chk.sv =====
module trhfe_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [trhfe_pkg::SUM_W-1:0]   i_out_mean,
    input  logic                          i_out_done
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one step in flight: no request taken right after another
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while a step is in progress");

    // mean error reported only on the final step
    a_mean_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_done |-> i_out_mean == '0)
        else $error("mean error on a step that is not the last");

    // a result cannot appear the cycle after a request
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result came out too early");

endmodule

bind two_reaction_heat_flow_error_top trhfe_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mean  (o_out.mean_error),
    .i_out_done  (o_out.done_res)
);
